/* rtl/lcs_pkg.sv */
// lcs_pkg: sizes, register indexes, types and the life rule for the cell stencil
package lcs_pkg;

   localparam int unsigned MAX_WIDTH    = 1024;
   localparam int unsigned HEIGHT_LIMIT = 1024;
   localparam int unsigned COL_W        = $clog2(MAX_WIDTH);
   localparam int unsigned DIM_W        = 11;
   localparam int unsigned CSR_ADDR_W   = 2;

   typedef logic [DIM_W-1:0] dim_type;
   typedef logic [COL_W-1:0] col_type;

   localparam dim_type DIM_MIN      = dim_type'(3);
   localparam dim_type WIDTH_RESET  = dim_type'(80);
   localparam dim_type HEIGHT_RESET = dim_type'(24);
   localparam dim_type WIDTH_MAX    = dim_type'(MAX_WIDTH);
   localparam dim_type HEIGHT_MAX   = dim_type'(HEIGHT_LIMIT);

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic next_alive;
      logic frame_end;
   } result_type;

   function automatic dim_type clamp_dim(input dim_type value, input dim_type limit);
      dim_type res;
      res = value;
      if (value < DIM_MIN) res = DIM_MIN;
      if (value > limit) res = limit;
      return res;
   endfunction

   // win: bits 0..2 left column, 3..5 centre, 6..8 right; bit 4 is the cell itself
   function automatic logic next_state(input logic [8:0] win);
      logic [3:0] count;
      logic       res;
      count = 4'd0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) count = count + {3'd0, win[i]};
      end
      if (count == BIRTH_COUNT) res = 1'b1;
      else if (count == SURVIVE_COUNT) res = win[4];
      else res = 1'b0;
      return res;
   endfunction

endpackage

/* rtl/lcs_req_if.sv */
// lcs_req_if: input channel carrying one grid cell per item
interface lcs_req_if;
   logic valid;
   logic ready;
   logic cell_alive;
   logic drain;

   modport source (output valid, output cell_alive, output drain, input ready);
   modport sink   (input valid, input cell_alive, input drain, output ready);
endinterface

/* rtl/lcs_rsp_if.sv */
// lcs_rsp_if: result channel carrying one next-generation cell per item
interface lcs_rsp_if;
   logic valid;
   logic ready;
   logic next_alive;
   logic frame_end;

   modport source (output valid, output next_alive, output frame_end, input ready);
   modport sink   (input valid, input next_alive, input frame_end, output ready);
endinterface

/* rtl/life_cell_stencil.sv */
// life_cell_stencil: one generation of life (B3/S23) over a raster-order cell stream
//
// Cells enter on req_in in raster order, one item per cell, and after each frame
// grid_width+1 drain items flush the last row. Each cell's next state leaves on
// rsp_out once the item at its lower-right neighbour's position has been taken;
// frame_end marks the frame's bottom-right cell. Positions outside the grid are dead.
// The result caused by an item is registered in the output register, or in the skid
// register while that is full. Throughput: one item per cycle while req_in.ready is
// high, set by the single line-store memory, which is read for the next column every
// cycle and written for the current one on each accepted item. csr_we, csr_addr and
// csr_wdata write grid_width (0) and grid_height (1), clamped to 3..1024; a write to
// either restarts the frame. Write only while the block is idle. Reset sets 80 x 24
// and restarts the frame; the line stores are not cleared, as rows outside the frame
// are masked by the row counter. Results sit in an output register backed by a skid
// register, so req_in.ready only drops once two results wait on a stalled receiver.
module life_cell_stencil
   import lcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lcs_req_if.sink               req_in,
   lcs_rsp_if.source             rsp_out,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata
);

   dim_type    width_ff, width_in;
   dim_type    height_ff, height_in;
   col_type    col_ff, col_in;
   dim_type    row_ff, row_in;
   logic [8:0] window_ff, window_in;

   // bit 1 upper line, bit 0 middle line
   logic [1:0] line_mem [MAX_WIDTH];
   logic [1:0] line_rd_ff;

   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;

   logic       accept, pop, push, emit, last;
   logic       top, mid, bot;
   logic [2:0] col_cells;
   logic [8:0] win;
   result_type result;

   assign accept = req_in.valid && req_in.ready;
   assign pop    = out_valid_ff && rsp_out.ready;
   assign push   = accept && emit;

   assign req_in.ready       = !skid_valid_ff;
   assign rsp_out.valid      = out_valid_ff;
   assign rsp_out.next_alive = out_data_ff.next_alive;
   assign rsp_out.frame_end  = out_data_ff.frame_end;

   always_comb begin
      top = (row_ff >= dim_type'(2)) ? line_rd_ff[1] : 1'b0;
      mid = (row_ff >= dim_type'(1) && row_ff <= height_ff) ? line_rd_ff[0] : 1'b0;
      bot = (row_ff < height_ff && !req_in.drain) ? req_in.cell_alive : 1'b0;
      col_cells = {bot, mid, top};

      if (col_ff == '0) begin
         // right-hand column of the previous row: its right side is dead
         win       = {3'b000, window_ff[8:3]};
         window_in = {col_cells, 6'b000000};
         emit      = (row_ff >= dim_type'(2));
      end else begin
         win       = {col_cells, window_ff[8:3]};
         window_in = win;
         emit      = (row_ff >= dim_type'(1));
      end

      last = (row_ff == height_ff + dim_type'(1)) && (col_ff == '0);
      result.next_alive = next_state(win);
      result.frame_end  = last;

      col_in    = col_ff;
      row_in    = row_ff;
      width_in  = width_ff;
      height_in = height_ff;

      if (csr_we) begin
         case (csr_reg_type'(csr_addr))
            REG_GRID_WIDTH: begin
               width_in = clamp_dim(csr_wdata, WIDTH_MAX);
            end
            REG_GRID_HEIGHT: begin
               height_in = clamp_dim(csr_wdata, HEIGHT_MAX);
            end
            default: begin
            end
         endcase
         if (csr_reg_type'(csr_addr) == REG_GRID_WIDTH ||
             csr_reg_type'(csr_addr) == REG_GRID_HEIGHT) begin
            col_in    = '0;
            row_in    = '0;
            window_in = '0;
         end else begin
            window_in = window_ff;
         end
      end else if (accept) begin
         if (last) begin
            col_in    = '0;
            row_in    = '0;
            window_in = '0;
         end else if (dim_type'(col_ff) + dim_type'(1) == width_ff) begin
            col_in = '0;
            row_in = row_ff + dim_type'(1);
         end else begin
            col_in = col_ff + col_type'(1);
         end
      end else begin
         window_in = window_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         window_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         window_ff <= window_in;
      end
   end

   // read ahead at the column of the next item, write back the current column
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[col_ff] <= {mid, bot};
      end
      line_rd_ff <= line_mem[col_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop && skid_valid_ff) begin
         out_data_ff   <= skid_data_ff;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         out_valid_ff <= push;
         if (push) out_data_ff <= result;
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= result;
         end else begin
            skid_valid_ff <= 1'b1;
            skid_data_ff  <= result;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while the output register is empty");

   assert property (@(posedge clock) disable iff (reset) dim_type'(col_ff) < width_ff)
      else $error("column count outside the row");

   assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_ff + dim_type'(1))
      else $error("row count past the flush row");

   assert property (@(posedge clock) disable iff (reset)
      accept && last && !csr_we |=> out_valid_ff && col_ff == '0 && row_ff == '0)
      else $error("frame end did not leave a result and restart the frame");

   assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_reg_type'(csr_addr) == REG_GRID_WIDTH ||
                 csr_reg_type'(csr_addr) == REG_GRID_HEIGHT)
      |=> col_ff == '0 && row_ff == '0 && window_ff == '0)
      else $error("register write did not restart the frame");

endmodule

/* tb/tb_life_cell_stencil.sv */
// tb_life_cell_stencil: self-checking bench for the life cell stencil against a grid predictor
`timescale 1ns / 1ps

module tb_life_cell_stencil;
   import lcs_pkg::*;

   localparam int unsigned CLOCK_PERIOD   = 10;
   localparam int unsigned RESET_CYCLES   = 8;
   localparam int unsigned RANDOM_ITEMS   = 700;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned RECEIVER_HOLD  = 300;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int unsigned DIRECTED_COUNT = 26;
   localparam int unsigned DIRECTED_W     = $clog2(DIRECTED_COUNT);
   localparam int unsigned CUT_LIMIT      = 64;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_LOW  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_HIGH = 2'd3;

   typedef struct packed {
      logic alive;
      logic drain;
      logic typed;
      logic fires;
      logic next_alive;
      logic frame_end;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   dim_type csr_wdata;

   lcs_req_if req_bus ();
   lcs_rsp_if rsp_bus ();

   life_cell_stencil dut (
      .clock     (clock),
      .reset     (reset),
      .req_in    (req_bus),
      .rsp_out   (rsp_bus),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the block state
   logic        upper_row [MAX_WIDTH];
   logic        middle_row [MAX_WIDTH];
   logic [8:0]  window_bits;
   int unsigned col_pos;
   int unsigned row_pos;
   dim_type     width_reg;
   dim_type     height_reg;

   result_type expected_cells [$];

   int unsigned items_sent;
   int unsigned random_items;
   int unsigned results_checked;
   int unsigned mismatches;
   int unsigned quiet_cycles;
   int unsigned size_settings;
   int unsigned width_low, width_high, height_low, height_high;
   bit          counting;
   bit          no_gaps;
   bit          hold_pending;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // 3x3 blinker, horizontal bar turns vertical; flush carries stray live cells
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
      // full grid with a drain item standing in for the centre cell
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
   };

   int unsigned densities [4] = '{8, 35, 50, 85};

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned clamp_size(input dim_type value, input int unsigned limit);
      int unsigned size;
      size = 32'(value);
      if (size < DIM_MIN) size = DIM_MIN;
      if (size > limit) size = limit;
      return size;
   endfunction

   function automatic void restart_grid();
      window_bits = '0;
      col_pos = 0;
      row_pos = 0;
   endfunction

   // moves the grid on by one item; returns 1 when a cell's next state comes out
   function automatic bit advance_grid(input logic alive, input logic drain_in,
                                       output result_type outcome);
      int unsigned w, h, r, c, count;
      logic        top, mid, bot;
      logic [2:0]  column;
      logic [8:0]  win;
      bit          fires, last;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, HEIGHT_LIMIT);
      r = row_pos;
      c = col_pos;
      top = (r >= 2) ? upper_row[col_type'(c)] : 1'b0;
      mid = (r >= 1 && r - 1 < h) ? middle_row[col_type'(c)] : 1'b0;
      bot = (r < h && !drain_in) ? alive : 1'b0;
      column = {bot, mid, top};
      upper_row[col_type'(c)] = mid;
      middle_row[col_type'(c)] = bot;
      if (c == 0) begin
         // first column of a row closes the previous row's right-hand cell
         win = {3'b000, window_bits[8:3]};
         window_bits = {column, 6'b000000};
         fires = (r >= 2);
      end else begin
         win = {column, window_bits[8:3]};
         window_bits = win;
         fires = (r >= 1);
      end
      count = $countones(win) - win[4];
      outcome.next_alive = (count == BIRTH_COUNT) || (count == SURVIVE_COUNT && win[4]);
      last = (r == h + 1) && (c == 0);
      outcome.frame_end = last;
      if (last) begin
         restart_grid();
      end else begin
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         col_pos = c;
         row_pos = r;
      end
      return fires;
   endfunction

   task automatic write_register(input logic [CSR_ADDR_W-1:0] index, input dim_type value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == REG_GRID_WIDTH) begin
         width_reg = value;
         restart_grid();
      end else if (index == REG_GRID_HEIGHT) begin
         height_reg = value;
         restart_grid();
      end
   endtask

   task automatic offer_cell(input logic alive, input logic drain_in);
      if (!no_gaps) begin
         while ($urandom_range(99) < 33) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid <= 1'b1;
      req_bus.cell_alive <= alive;
      req_bus.drain <= drain_in;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic stream_cell(input logic alive, input logic drain_in);
      result_type outcome;
      offer_cell(alive, drain_in);
      if (advance_grid(alive, drain_in, outcome)) expected_cells.push_back(outcome);
      items_sent++;
      if (counting) begin
         random_items++;
         no_gaps = (random_items >= 150 && random_items < 300);
         if (random_items == 400) hold_pending = 1'b1;
      end
   endtask

   // one frame of random cells then its flush; cut_short stops somewhere before the end
   task automatic stream_frame(input int unsigned density, input bit cut_short);
      int unsigned w, h, cells, total, stop, cap, k;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, HEIGHT_LIMIT);
      cells = w * h;
      total = cells + w + 1;
      stop = total;
      if (cut_short) begin
         cap = (4 * w < CUT_LIMIT) ? 4 * w : CUT_LIMIT;
         if (cap > total - 1) cap = total - 1;
         stop = $urandom_range(1, cap);
      end
      for (k = 0; k < stop; k++) begin
         if (k < cells) stream_cell($urandom_range(99) < density, $urandom_range(99) < 3);
         else stream_cell($urandom_range(1) == 1, $urandom_range(99) < 85);
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic note_sizes();
      int unsigned w, h;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, HEIGHT_LIMIT);
      size_settings++;
      if (w < width_low) width_low = w;
      if (w > width_high) width_high = w;
      if (h < height_low) height_low = h;
      if (h > height_high) height_high = h;
   endtask

   // receiver: random back-pressure, one long hold-off while the sender keeps going
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RECEIVER_HOLD) @(posedge clock);
         end
         rsp_bus.ready <= no_gaps || ($urandom_range(99) >= 33);
      end
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_checked++;
         if (expected_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: next_alive %b frame_end %b",
                        rsp_bus.next_alive, rsp_bus.frame_end);
         end else begin
            want = expected_cells.pop_front();
            if (rsp_bus.next_alive !== want.next_alive || rsp_bus.frame_end !== want.frame_end)
            begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch at result %0d: expected next_alive %b frame_end %b, got %b %b",
                           results_checked, want.next_alive, want.frame_end,
                           rsp_bus.next_alive, rsp_bus.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned      k, f, frames, phase, which;
      bit               fires, cut_frame;
      result_type       outcome;
      dim_type          new_width, new_height;
      directed_row_type entry;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = REG_GRID_WIDTH;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cell_alive = 1'b0;
      req_bus.drain = 1'b0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      upper_row = '{default: 1'b0};
      middle_row = '{default: 1'b0};
      restart_grid();
      items_sent = 0;
      random_items = 0;
      results_checked = 0;
      mismatches = 0;
      quiet_cycles = 0;
      size_settings = 0;
      width_low = MAX_WIDTH;
      width_high = 0;
      height_low = HEIGHT_LIMIT;
      height_high = 0;
      counting = 1'b1;
      no_gaps = 1'b0;
      hold_pending = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: a couple of rows at 80 wide, then cut off by the next write
      note_sizes();
      for (k = 0; k < 200; k++) stream_cell($urandom_range(99) < 35, $urandom_range(99) < 3);
      settle();

      write_register(REG_GRID_WIDTH, DIM_MIN);
      write_register(REG_GRID_HEIGHT, DIM_MIN);
      note_sizes();
      for (k = 0; k < DIRECTED_COUNT; k++) begin
         entry = directed_rows[DIRECTED_W'(k)];
         offer_cell(entry.alive, entry.drain);
         fires = advance_grid(entry.alive, entry.drain, outcome);
         if (entry.typed) begin
            fires = entry.fires;
            outcome.next_alive = entry.next_alive;
            outcome.frame_end = entry.frame_end;
         end
         if (fires) expected_cells.push_back(outcome);
         items_sent++;
      end
      settle();

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         counting = 1'b1;
         which = 0;
         frames = 1;
         cut_frame = 1'b0;
         if (phase == 1) begin
            // widest row with all data bits set, height clamped up from zero
            new_width = '1;
            new_height = '0;
            cut_frame = 1'b1;
         end else if (phase == 3) begin
            new_width = dim_type'(2);
            new_height = HEIGHT_MAX;
            cut_frame = 1'b1;
         end else if (phase == 5) begin
            new_width = dim_type'($urandom_range(4, 6));
            new_height = '1;
            cut_frame = 1'b1;
         end else begin
            new_width = ($urandom_range(99) < 15) ? dim_type'($urandom_range(0, 2))
                                                  : dim_type'($urandom_range(3, 9));
            new_height = ($urandom_range(99) < 15) ? dim_type'($urandom_range(0, 2))
                                                   : dim_type'($urandom_range(3, 8));
            which = $urandom_range(2);
            frames = $urandom_range(1, 3);
            cut_frame = ($urandom_range(99) < 25);
         end
         if (which != 2) write_register(REG_GRID_WIDTH, new_width);
         if (which != 1) write_register(REG_GRID_HEIGHT, new_height);
         if ($urandom_range(4) == 0)
            write_register($urandom_range(1) ? REG_SPARE_HIGH : REG_SPARE_LOW,
                           dim_type'($urandom));
         note_sizes();
         for (f = 0; f < frames; f++)
            stream_frame(densities[2'($urandom_range(3))], cut_frame && (f == frames - 1));
         settle();
         phase++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatches += expected_cells.size();
      $display("covered %0d items and %0d checked results over %0d size settings",
               items_sent, results_checked, size_settings);
      $display("widths %0d..%0d, heights %0d..%0d, drains mid-frame, stray live flush cells",
               width_low, width_high, height_low, height_high);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule
